FILE: sv/assert_macros.svh
// assertion macros used by the scorer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define FSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/fss_pkg.sv
// types, constants and character class functions of the fuzzy subsequence scorer
`default_nettype none

package fss_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned PIDX_W   = 5;
    localparam int unsigned SCORE_W  = 11;
    localparam int unsigned RUN_W    = 4;
    localparam int unsigned GAP_W    = 4;
    localparam int unsigned TLEN_W   = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned PAT_SLOTS = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    localparam logic [SCORE_W-1:0] CHAR_SCORE   = 11'd10;
    localparam logic [SCORE_W-1:0] WORD_BONUS   = 11'd15;
    localparam logic [SCORE_W-1:0] PREFIX_BONUS = 11'd25;
    localparam logic [3:0]         SHORT_BASE   = 4'd15;
    localparam logic [GAP_W-1:0]   GAP_CAP      = 4'd8;
    localparam logic [TLEN_W-1:0]  TLEN_SAT     = 5'd31;

    typedef logic [PAT_SLOTS-1:0][CHAR_W-1:0] t_pattern;

    typedef struct packed {
        logic [PIDX_W-1:0]  pidx;
        logic [SCORE_W-1:0] score;
        logic [RUN_W-1:0]   run;
        logic               prev_matched;
        logic [CHAR_W-1:0]  prev_char;
        logic [GAP_W-1:0]   gap;
        logic [TLEN_W-1:0]  tlen;
        logic               prefix_intact;
    } t_text_state;

    typedef struct packed {
        logic               matched;
        logic [SCORE_W-1:0] score;
    } t_result;

    localparam t_text_state TEXT_STATE_RESET = '{
        pidx: '0, score: '0, run: '0, prev_matched: 1'b0,
        prev_char: '0, gap: '0, tlen: '0, prefix_intact: 1'b1
    };

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= "A") && (c <= "Z");
    endfunction

    function automatic logic is_lower_or_digit(input logic [CHAR_W-1:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "0") && (c <= "9"));
    endfunction

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return is_upper(c) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        logic r;
        case (c)
            " ", ".", "-", "_", "/", ":", "(", ")", "&": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fuzzy_subsequence_scorer_unit.sv
// Fuzzy subsequence scorer: takes one text character per cycle and, on the character marked
// as last, produces one matched flag and score. A request passes an input register and then
// the scoring logic into a result register. The text state register feeds back through the
// scoring logic, which sets the rate at one character per clock while the input side does not
// stall. The input side stalls only when a final character sits in the input register while
// an earlier result is still held by the output side. Configuration writes are always ready
// and act on the next character.
`default_nettype none

module fuzzy_subsequence_scorer_unit import fss_pkg::*; #(
    parameter int unsigned MAX_PATTERN = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CHAR_W-1:0]     i_text_char,
    input  wire logic                  i_text_end,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_matched,
    output logic [SCORE_W-1:0]         o_match_score,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam logic [PIDX_W-1:0] MaxLen = PIDX_W'(MAX_PATTERN);

    logic [PIDX_W-1:0]     r_len;
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic                  r_in_valid;
    logic [CHAR_W-1:0]     r_in_char;
    logic                  r_in_end;
    t_text_state           r_st;
    logic                  r_out_valid;
    t_result               r_out;

    t_text_state       n_st;
    t_result           step_result;
    logic [PIDX_W-1:0] len_act;
    t_pattern          pattern;
    logic              step_en;
    logic              advance;
    logic              in_take;

    assign len_act = (r_len > MaxLen) ? MaxLen : r_len;
    assign pattern = {r_pat_hi, r_pat_lo};

    assign advance    = !r_in_end || !r_out_valid || !i_out_stall;
    assign step_en    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    fss_step u_step (
        .i_state   (r_st),
        .i_char    (r_in_char),
        .i_last    (r_in_end),
        .i_len     (len_act),
        .i_pattern (pattern),
        .o_state   (n_st),
        .o_result  (step_result)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_pat_lo <= '0;
            r_pat_hi <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[PIDX_W-1:0];
                CFG_PATTERN_LOW:    r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_text_char;
            r_in_end  <= i_text_end;
        end
    end

    // text state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= TEXT_STATE_RESET;
        end else if (step_en) begin
            r_st <= n_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en && r_in_end) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_matched     = r_out.matched;
    assign o_match_score = r_out.score;

    `FSS_ASSERT(a_unmatched_zero,
        (r_out_valid && !r_out.matched) |-> (r_out.score == '0),
        "unmatched result carries a score")
    `FSS_ASSERT(a_state_cleared,
        (step_en && r_in_end) |=> ((r_st.pidx == '0) && (r_st.tlen == '0) && r_st.prefix_intact),
        "text state not cleared after final character")
    `FSS_ASSERT(a_result_kept,
        (r_out_valid && i_out_stall) |=> r_out_valid,
        "waiting result dropped")
    `FSS_ASSERT_ALWAYS(a_reset_idle,
        (!i_rst_n) |=> (!r_in_valid && !r_out_valid),
        "pipeline not empty after reset")

endmodule

`default_nettype wire

FILE: sv/fss_step.sv
// per character match, score and result logic of the fuzzy subsequence scorer
`default_nettype none

module fss_step import fss_pkg::*; (
    input  wire t_text_state       i_state,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_last,
    input  wire logic [PIDX_W-1:0] i_len,
    input  wire t_pattern          i_pattern,
    output t_text_state            o_state,
    output t_result                o_result
);

    logic              word_start;
    logic              hit;
    logic [CHAR_W-1:0] pat_char;
    logic [RUN_W-1:0]  run_inc;
    logic [SCORE_W-1:0] add;
    logic [SCORE_W-1:0] run_bonus;
    logic [3:0]        half;
    logic [SCORE_W-1:0] short_bonus;
    logic [SCORE_W-1:0] final_score;
    t_text_state       nxt;

    assign pat_char   = i_pattern[i_state.pidx[3:0]];
    assign word_start = (i_state.tlen == '0) || is_sep(i_state.prev_char)
                        || (is_lower_or_digit(i_state.prev_char) && is_upper(i_char));
    assign hit        = (i_state.pidx < i_len) && (fold(i_char) == fold(pat_char));
    assign run_inc    = i_state.run + 4'd1;
    assign run_bonus  = (SCORE_W'(run_inc) << 2) + SCORE_W'(run_inc);

    always_comb begin
        add = CHAR_SCORE;
        if (word_start) begin
            add = add + WORD_BONUS;
        end
        if (i_state.prev_matched) begin
            add = add + run_bonus;
        end
    end

    always_comb begin
        nxt = i_state;
        if (hit) begin
            nxt.run          = i_state.prev_matched ? run_inc : '0;
            nxt.score        = i_state.score + add - SCORE_W'(i_state.gap);
            nxt.pidx         = i_state.pidx + 5'd1;
            nxt.gap          = '0;
            nxt.prev_matched = 1'b1;
            if (i_state.gap != '0) begin
                nxt.prefix_intact = 1'b0;
            end
        end else begin
            nxt.prev_matched = 1'b0;
            if ((i_state.pidx < i_len) && (i_state.gap < GAP_CAP)) begin
                nxt.gap = i_state.gap + 4'd1;
            end
        end
        nxt.prev_char = i_char;
        if (i_state.tlen < TLEN_SAT) begin
            nxt.tlen = i_state.tlen + 5'd1;
        end
    end

    assign half        = nxt.tlen[TLEN_W-1:1];
    assign short_bonus = (half < SHORT_BASE) ? SCORE_W'(SHORT_BASE - half) : '0;
    assign final_score = nxt.score + (nxt.prefix_intact ? PREFIX_BONUS : '0) + short_bonus;

    always_comb begin
        if (i_len == '0) begin
            o_result.matched = 1'b1;
            o_result.score   = '0;
        end else if (nxt.pidx >= i_len) begin
            o_result.matched = 1'b1;
            o_result.score   = final_score;
        end else begin
            o_result.matched = 1'b0;
            o_result.score   = '0;
        end
    end

    assign o_state = i_last ? TEXT_STATE_RESET : nxt;

endmodule

`default_nettype wire
